[hw/rtl/srdff_pkg.sv]
// Shared types, register codes and constants of the speed-reference derivative feed-forward.
package srdff_pkg;

    // Field widths
    localparam int GAIN_W   = 31;
    localparam int TICKS_W  = 16;
    localparam int VALUE_W  = 32;
    localparam int REF_W    = 16;
    localparam int CFG_ADDR_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN         = 2'd0,
        REG_SAMPLE_TICKS = 2'd1,
        REG_CLAMP_LOW    = 2'd2,
        REG_CLAMP_HIGH   = 2'd3
    } t_cfg_reg;

    // Input action codes
    localparam logic ACT_INIT    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // Register reset values
    localparam logic [GAIN_W-1:0]         GAIN_RST       = 31'd0;
    localparam logic [TICKS_W-1:0]        TICKS_RST      = 16'd100;
    localparam logic signed [VALUE_W-1:0] CLAMP_LOW_RST  = 32'shfe000000;
    localparam logic [GAIN_W-1:0]         CLAMP_HIGH_RST = 31'h01ff0000;

    // Arithmetic constants
    localparam logic [3:0]         DERIV_SCALE = 4'd10;
    localparam logic [VALUE_W-1:0] POS_LIMIT   = 32'h7fffffff;
    localparam logic [VALUE_W-1:0] NEG_LIMIT   = 32'h80000000;

    // Configuration bundle handed to the datapath
    typedef struct packed {
        logic [GAIN_W-1:0]         gain;
        logic [TICKS_W-1:0]        sample_ticks;
        logic signed [VALUE_W-1:0] clamp_low;
        logic [GAIN_W-1:0]         clamp_high;
    } t_cfg;

endpackage

[hw/rtl/srdff_deriv.sv]
// Reference derivative tracker: latched reference, latched time and held derivative.
module srdff_deriv (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_upd,
    input  logic                                i_action,
    input  logic signed [srdff_pkg::REF_W-1:0]  i_ref,
    input  logic [srdff_pkg::TICKS_W-1:0]       i_now,
    input  logic [srdff_pkg::TICKS_W-1:0]       i_sample_ticks,
    output logic signed [srdff_pkg::REF_W-1:0]  o_deriv
);

    logic signed [srdff_pkg::REF_W-1:0] r_prev_ref, n_prev_ref;
    logic [srdff_pkg::TICKS_W-1:0]      r_prev_time, n_prev_time;
    logic signed [srdff_pkg::REF_W-1:0] r_held, n_held;

    logic [srdff_pkg::TICKS_W-1:0]      w_elapsed;
    logic [srdff_pkg::REF_W-1:0]        w_diff;
    logic [srdff_pkg::REF_W-1:0]        w_scaled;

    // Elapsed ticks wrap at 16 bits; difference scaled and wrapped to 16 bits
    assign w_elapsed = i_now - r_prev_time;
    assign w_diff    = i_ref - r_prev_ref;
    assign w_scaled  = w_diff * srdff_pkg::REF_W'(srdff_pkg::DERIV_SCALE);

    // Work out the state left by this transaction
    always_comb begin
        n_prev_ref  = r_prev_ref;
        n_prev_time = r_prev_time;
        n_held      = r_held;
        if (i_action == srdff_pkg::ACT_INIT) begin
            n_prev_ref  = i_ref;
            n_prev_time = i_now;
            n_held      = '0;
        end else if (w_elapsed >= i_sample_ticks) begin
            n_prev_ref  = i_ref;
            n_prev_time = i_now;
            n_held      = $signed(w_scaled);
        end
    end

    assign o_deriv = n_held;

    // Commit the state when the transaction moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ref  <= '0;
            r_prev_time <= '0;
            r_held      <= '0;
        end else if (i_upd) begin
            r_prev_ref  <= n_prev_ref;
            r_prev_time <= n_prev_time;
            r_held      <= n_held;
        end
    end

endmodule

[hw/rtl/srdff_gain.sv]
// Gain product with saturation, sum with the base value and output clamp.
module srdff_gain (
    input  logic                                  i_action,
    input  logic signed [srdff_pkg::REF_W-1:0]    i_deriv,
    input  logic signed [srdff_pkg::VALUE_W-1:0]  i_base,
    input  srdff_pkg::t_cfg                       i_cfg,
    output logic signed [srdff_pkg::VALUE_W-1:0]  o_result,
    output logic signed [srdff_pkg::REF_W-1:0]    o_term_high
);

    localparam int PROD_W = srdff_pkg::REF_W + srdff_pkg::GAIN_W;

    logic                                d_neg;
    logic [srdff_pkg::REF_W-1:0]         w_mag;
    logic [PROD_W-1:0]                   w_mag_prod;
    logic [PROD_W:0]                     w_sat_sum;
    logic                                w_sat;
    logic [srdff_pkg::VALUE_W-1:0]       w_prod;
    logic signed [srdff_pkg::VALUE_W:0]  w_sum;
    logic signed [srdff_pkg::VALUE_W-1:0] w_sum32;
    logic signed [srdff_pkg::VALUE_W-1:0] w_high_s;
    logic                                w_over;
    logic                                w_under;
    logic                                w_bypass;

    // Magnitude product; the saturation test is |d|*gain + gain past the positive limit
    assign d_neg      = i_deriv[srdff_pkg::REF_W-1];
    assign w_mag      = d_neg ? (-i_deriv) : i_deriv;
    assign w_mag_prod = PROD_W'(w_mag) * PROD_W'(i_cfg.gain);
    assign w_sat_sum  = {1'b0, w_mag_prod} + (PROD_W+1)'(i_cfg.gain);
    assign w_sat      = w_sat_sum > (PROD_W+1)'(srdff_pkg::POS_LIMIT);

    // Signed product, pinned to the limits on saturation
    always_comb begin
        if (w_sat) begin
            w_prod = d_neg ? srdff_pkg::NEG_LIMIT : srdff_pkg::POS_LIMIT;
        end else if (d_neg) begin
            w_prod = -w_mag_prod[srdff_pkg::VALUE_W-1:0];
        end else begin
            w_prod = w_mag_prod[srdff_pkg::VALUE_W-1:0];
        end
    end

    // Sum with overflow detection from the two top bits
    assign w_sum    = {w_prod[srdff_pkg::VALUE_W-1], w_prod}
                    + {i_base[srdff_pkg::VALUE_W-1], i_base};
    assign w_over   = !w_sum[srdff_pkg::VALUE_W] && w_sum[srdff_pkg::VALUE_W-1];
    assign w_under  = w_sum[srdff_pkg::VALUE_W] && !w_sum[srdff_pkg::VALUE_W-1];
    assign w_sum32  = w_sum[srdff_pkg::VALUE_W-1:0];
    assign w_high_s = $signed({1'b0, i_cfg.clamp_high});
    assign w_bypass = (i_action == srdff_pkg::ACT_INIT) || (i_cfg.gain == '0);

    // Clamp, bypassed on init or zero gain: low limit tested before high limit
    always_comb begin
        o_term_high = '0;
        if (w_bypass) begin
            o_result = i_base;
        end else begin
            o_term_high = w_prod[srdff_pkg::VALUE_W-1:srdff_pkg::VALUE_W-srdff_pkg::REF_W];
            if (w_over) begin
                o_result = w_high_s;
            end else if (w_under) begin
                o_result = i_cfg.clamp_low;
            end else if (w_sum32 < i_cfg.clamp_low) begin
                o_result = i_cfg.clamp_low;
            end else if (w_sum32 >= w_high_s) begin
                o_result = w_high_s;
            end else begin
                o_result = w_sum32;
            end
        end
    end

endmodule

[hw/rtl/speed_ref_derivative_feedforward_unit.sv]
// Top level of the speed-reference derivative feed-forward: stream ports, registers, pipeline.
//
// One result per input transaction, one transaction per clock sustained while results are
// taken. A transaction lands in the input register, passes combinationally through the
// derivative update, the 16 x 31 bit gain multiply with its saturation test, the sum and the
// clamp, and is held in the result register. That one pass between the input and result
// registers sets the rate. The input side keeps accepting while a result waits, until both
// registers are full. No clearing pass is needed after reset.
module speed_ref_derivative_feedforward_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [srdff_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [srdff_pkg::VALUE_W-1:0]          i_cfg_wdata,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [63:0]                            s_tdata,  // speed_ref, now_time, base_value
    input  logic [0:0]                             s_tuser,  // action
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [63:0]                            m_tdata   // result_value, ref_derivative,
                                                             // term_high
);

    srdff_pkg::t_cfg r_cfg;

    logic                                  r_in_vld;
    logic                                  r_in_action;
    logic signed [srdff_pkg::REF_W-1:0]    r_in_ref;
    logic [srdff_pkg::TICKS_W-1:0]         r_in_now;
    logic signed [srdff_pkg::VALUE_W-1:0]  r_in_base;

    logic                                  r_out_vld;
    logic [63:0]                           r_out_data;

    logic                                  w_adv;
    logic signed [srdff_pkg::REF_W-1:0]    w_deriv;
    logic signed [srdff_pkg::VALUE_W-1:0]  w_result;
    logic signed [srdff_pkg::REF_W-1:0]    w_term_high;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain         <= srdff_pkg::GAIN_RST;
            r_cfg.sample_ticks <= srdff_pkg::TICKS_RST;
            r_cfg.clamp_low    <= srdff_pkg::CLAMP_LOW_RST;
            r_cfg.clamp_high   <= srdff_pkg::CLAMP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (srdff_pkg::t_cfg_reg'(i_cfg_addr))
                srdff_pkg::REG_GAIN: begin
                    r_cfg.gain <= i_cfg_wdata[srdff_pkg::GAIN_W-1:0];
                end
                srdff_pkg::REG_SAMPLE_TICKS: begin
                    r_cfg.sample_ticks <= i_cfg_wdata[srdff_pkg::TICKS_W-1:0];
                end
                srdff_pkg::REG_CLAMP_LOW: begin
                    r_cfg.clamp_low <= i_cfg_wdata;
                end
                srdff_pkg::REG_CLAMP_HIGH: begin
                    r_cfg.clamp_high <= i_cfg_wdata[srdff_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline advance: the result register frees when empty or taken
    assign w_adv    = !r_out_vld || m_tready;
    assign s_tready = !r_in_vld || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tready) begin
            r_in_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_action <= s_tuser[0];
            r_in_ref    <= s_tdata[15:0];
            r_in_now    <= s_tdata[31:16];
            r_in_base   <= s_tdata[63:32];
        end
    end

    // Derivative state, committed as the transaction advances
    srdff_deriv u_deriv (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_upd          (r_in_vld && w_adv),
        .i_action       (r_in_action),
        .i_ref          (r_in_ref),
        .i_now          (r_in_now),
        .i_sample_ticks (r_cfg.sample_ticks),
        .o_deriv        (w_deriv)
    );

    srdff_gain u_gain (
        .i_action    (r_in_action),
        .i_deriv     (w_deriv),
        .i_base      (r_in_base),
        .i_cfg       (r_cfg),
        .o_result    (w_result),
        .o_term_high (w_term_high)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_vld) begin
            r_out_data <= {w_term_high, w_deriv, w_result};
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_data;

endmodule

[hw/rtl/srdff_checker.sv]
// Port-level checks of the speed-reference derivative feed-forward, bound to the top level.
module srdff_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Drop results after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid just after reset");

    // Input blocks only behind a waiting result
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with result side free");

    // A nonzero gain term needs a nonzero derivative
    a_term_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[63:48] != 16'd0) |-> (m_tdata[47:32] != 16'd0))
        else $error("gain term without derivative");

    // A negative gain term needs a negative derivative
    a_term_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[63] |-> m_tdata[47])
        else $error("gain term sign differs from derivative");

endmodule

bind speed_ref_derivative_feedforward_unit srdff_checker u_srdff_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
